FILE: rtl/mspp_pkg.sv
// Shared types, constants and register indexes for the motor speed PID/PWM block.
`timescale 1ns / 1ps

package mspp_pkg;

    // Configuration register indexes
    typedef logic [2:0] cfg_idx_t;

    localparam cfg_idx_t CFG_PROP_GAIN       = 3'd0;
    localparam cfg_idx_t CFG_INTEGRAL_GAIN   = 3'd1;
    localparam cfg_idx_t CFG_DERIVATIVE_GAIN = 3'd2;
    localparam cfg_idx_t CFG_COUNT_OFFSET    = 3'd3;
    localparam cfg_idx_t CFG_SPEED_SCALE     = 3'd4;
    localparam cfg_idx_t CFG_DUTY_LIMIT      = 3'd5;
    localparam cfg_idx_t CFG_DUTY_DEADBAND   = 3'd6;
    localparam cfg_idx_t CFG_HOLD_BAND       = 3'd7;

    localparam int CFG_DATA_W = 31;

    // Register reset values
    localparam logic [23:0] RST_PROP_GAIN       = 24'd45875;
    localparam logic [23:0] RST_INTEGRAL_GAIN   = 24'd1147;
    localparam logic [23:0] RST_DERIVATIVE_GAIN = 24'd786;
    localparam logic [15:0] RST_COUNT_OFFSET    = 16'd20000;
    localparam logic [23:0] RST_SPEED_SCALE     = 24'd262845;
    localparam logic [14:0] RST_DUTY_LIMIT      = 15'd25344;
    localparam logic [14:0] RST_DUTY_DEADBAND   = 15'd2560;
    localparam logic [30:0] RST_HOLD_BAND       = 31'd2048;

    // 100 percent in Q.8
    localparam logic [14:0] FULL_SCALE_Q8 = 15'd25600;
    // Cap on each gain term magnitude: 2^40
    localparam logic [40:0] TERM_CAP = 41'h10000000000;
    // ceil(2^30 / 100): exact floor division by 100 for 23-bit dividends
    localparam logic [23:0] RECIP_100   = 24'd10737419;
    localparam int          RECIP_SHIFT = 30;
    localparam logic [15:0] CMP_MAX     = 16'hFFFF;

    // Configuration register file contents
    typedef struct packed {
        logic [23:0] prop_gain;
        logic [23:0] integral_gain;
        logic [23:0] derivative_gain;
        logic [15:0] count_offset;
        logic [23:0] speed_scale;
        logic [14:0] duty_limit;
        logic [14:0] duty_deadband;
        logic [30:0] hold_band;
    } mspp_cfg_t;

    // Request to the shared multiplier
    typedef struct packed {
        logic        en;
        logic [23:0] a;
        logic [23:0] b;
    } mspp_mul_req_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPD_MUL,
        ST_SPEED,
        ST_ERROR,
        ST_INTEG,
        ST_TERM_LO,
        ST_TERM_HI,
        ST_TERM_ACC,
        ST_CLAMP,
        ST_DUTY,
        ST_CVT_MUL,
        ST_DONE
    } mspp_state_t;

endpackage

FILE: rtl/mspp_if.sv
// Valid/ready stream interfaces for control ticks and their results.
`timescale 1ns / 1ps

interface mspp_in_if;
    logic               valid;
    logic               ready;
    logic        [15:0] encoder_count;
    logic signed [31:0] setpoint_speed;

    modport source (output valid, output encoder_count, output setpoint_speed, input ready);
    modport sink   (input valid, input encoder_count, input setpoint_speed, output ready);
endinterface

interface mspp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] measured_speed;
    logic signed [15:0] duty_value;
    logic        [15:0] forward_compare;
    logic        [15:0] reverse_compare;
    logic               reversal;

    modport source (output valid, output measured_speed, output duty_value,
                    output forward_compare, output reverse_compare, output reversal,
                    input ready);
    modport sink   (input valid, input measured_speed, input duty_value,
                    input forward_compare, input reverse_compare, input reversal,
                    output ready);
endinterface

FILE: rtl/motor_speed_pid_pwm_top.sv
// Motor speed PID controller with PWM compare outputs, top level.
//
// Each request on in_ch is one control tick: the encoder count and the speed
// setpoint (rpm, signed Q24.8). The block measures speed as
// (count - count_offset) * speed_scale rounded to Q.8, runs one PID step with
// a saturating 48-bit integrator, clamps the duty to +-min(duty_limit, 100 %),
// zeroes magnitudes below duty_deadband, keeps the previous duty when the
// error is within hold_band, and returns one result request with the speed,
// the duty, forward/reverse compare values on a 0..65535 scale and a
// reversal flag. All products go through one shared 24x24 multiplier under a
// sequencer, so in_ch.ready stays low from the acceptance of a tick until
// the sequencer has stored its result in the output register and returned
// to idle (eight multiplies plus the add, saturate and clamp steps), and
// longer if the previous result is still waiting there. Configuration writes
// take effect at once and belong in idle time.
`timescale 1ns / 1ps

module motor_speed_pid_pwm_top
    import mspp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  cfg_idx_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    mspp_in_if.sink               in_ch,
    mspp_out_if.source            out_ch
);

    mspp_cfg_t cfg;

    mspp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mspp_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule

FILE: rtl/mspp_cfg.sv
// Configuration register file with a plain write port.
`timescale 1ns / 1ps

module mspp_cfg
    import mspp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  cfg_idx_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output mspp_cfg_t             cfg
);

    mspp_cfg_t cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain       <= RST_PROP_GAIN;
            cfg_reg.integral_gain   <= RST_INTEGRAL_GAIN;
            cfg_reg.derivative_gain <= RST_DERIVATIVE_GAIN;
            cfg_reg.count_offset    <= RST_COUNT_OFFSET;
            cfg_reg.speed_scale     <= RST_SPEED_SCALE;
            cfg_reg.duty_limit      <= RST_DUTY_LIMIT;
            cfg_reg.duty_deadband   <= RST_DUTY_DEADBAND;
            cfg_reg.hold_band       <= RST_HOLD_BAND;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_PROP_GAIN:       cfg_reg.prop_gain       <= cfg_data[23:0];
                CFG_INTEGRAL_GAIN:   cfg_reg.integral_gain   <= cfg_data[23:0];
                CFG_DERIVATIVE_GAIN: cfg_reg.derivative_gain <= cfg_data[23:0];
                CFG_COUNT_OFFSET:    cfg_reg.count_offset    <= cfg_data[15:0];
                CFG_SPEED_SCALE:     cfg_reg.speed_scale     <= cfg_data[23:0];
                CFG_DUTY_LIMIT:      cfg_reg.duty_limit      <= cfg_data[14:0];
                CFG_DUTY_DEADBAND:   cfg_reg.duty_deadband   <= cfg_data[14:0];
                CFG_HOLD_BAND:       cfg_reg.hold_band       <= cfg_data[30:0];
                default:             ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/mspp_mul.sv
// Shared 24x24 unsigned multiplier with registered product.
`timescale 1ns / 1ps

module mspp_mul
    import mspp_pkg::*;
(
    input  logic          clk,
    input  mspp_mul_req_t req,
    output logic [47:0]   prod
);

    logic [47:0] prod_reg;

    // Product holds until the next request
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= req.a * req.b;
        end
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/mspp_core.sv
// Sequencer and datapath: speed, PID step, duty shaping and PWM compare values.
`timescale 1ns / 1ps

module mspp_core
    import mspp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  mspp_cfg_t cfg,
    mspp_in_if.sink   in_ch,
    mspp_out_if.source out_ch
);

    localparam logic [1:0] TERM_P = 2'd0;
    localparam logic [1:0] TERM_I = 2'd1;
    localparam logic [1:0] TERM_D = 2'd2;

    // Saturate a 33-bit signed value to 32 bits
    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31])
        begin
            r = v[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    mspp_state_t state_reg, state_next;

    // Controller state
    logic signed [47:0] integ_reg;
    logic signed [31:0] last_err_reg;
    logic signed [15:0] last_duty_reg;

    // Working registers
    logic        [15:0] dmag_reg;
    logic               dneg_reg;
    logic signed [31:0] setp_reg;
    logic signed [31:0] speed_reg;
    logic signed [31:0] err_reg;
    logic signed [32:0] deriv_reg;
    logic signed [47:0] integ_new_reg;
    logic        [1:0]  term_sel_reg;
    logic        [31:0] part_reg;
    logic signed [42:0] sum_reg;
    logic signed [15:0] clamp_reg;
    logic signed [15:0] duty_reg;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_speed_reg;
    logic signed [15:0] out_duty_reg;
    logic        [15:0] out_fwd_reg;
    logic        [15:0] out_rev_reg;
    logic               out_revf_reg;

    mspp_mul_req_t mul_req;
    logic [47:0]   prod;

    logic accept;
    logic out_free;
    logic load;

    mspp_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    assign accept   = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;

    // Encoder delta magnitude and sign
    logic [16:0] diff;
    assign diff = {1'b0, in_ch.encoder_count} - {1'b0, cfg.count_offset};

    // Operand of the current gain term, its magnitude and gain
    logic signed [48:0] term_x;
    logic        [48:0] term_neg;
    logic        [47:0] term_mag;
    logic        [23:0] term_gain;

    always_comb
    begin
        unique case (term_sel_reg)
            TERM_P:
            begin
                term_x    = {{17{err_reg[31]}}, err_reg};
                term_gain = cfg.prop_gain;
            end
            TERM_I:
            begin
                term_x    = {integ_new_reg[47], integ_new_reg};
                term_gain = cfg.integral_gain;
            end
            default:
            begin
                term_x    = {{16{deriv_reg[32]}}, deriv_reg};
                term_gain = cfg.derivative_gain;
            end
        endcase
        term_neg = -term_x;
        term_mag = term_x[48] ? term_neg[47:0] : term_x[47:0];
    end

    // Speed from the encoder product
    logic signed [40:0] spd_p;
    logic signed [40:0] spd_r;
    logic signed [32:0] spd_q;
    always_comb
    begin
        spd_p = dneg_reg ? -$signed({1'b0, prod[39:0]}) : $signed({1'b0, prod[39:0]});
        spd_r = spd_p + 41'sd128;
        spd_q = spd_r[40:8];
    end

    // Integrator update
    logic signed [48:0] isum;
    logic signed [47:0] isat;
    always_comb
    begin
        isum = {integ_reg[47], integ_reg} + {{17{err_reg[31]}}, err_reg};
        if (isum[48] != isum[47])
        begin
            isat = isum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
        end
        else
        begin
            isat = isum[47:0];
        end
    end

    // Gain term: (hi*g << 8) + (lo*g >> 16), capped, signed
    logic        [56:0] term_r;
    logic        [40:0] term_c;
    logic signed [42:0] term_s;
    always_comb
    begin
        term_r = {1'b0, prod, 8'b0} + {25'b0, part_reg};
        term_c = (term_r > {16'b0, TERM_CAP}) ? TERM_CAP : term_r[40:0];
        term_s = term_x[48] ? -$signed({2'b0, term_c}) : $signed({2'b0, term_c});
    end

    // Clamp to the effective limit
    logic        [14:0] lim;
    logic signed [42:0] lim_s;
    logic signed [15:0] clamp_v;
    always_comb
    begin
        lim   = (cfg.duty_limit > FULL_SCALE_Q8) ? FULL_SCALE_Q8 : cfg.duty_limit;
        lim_s = $signed({28'b0, lim});
        if (sum_reg > lim_s)
        begin
            clamp_v = $signed({1'b0, lim});
        end
        else if (sum_reg < -lim_s)
        begin
            clamp_v = -$signed({1'b0, lim});
        end
        else
        begin
            clamp_v = sum_reg[15:0];
        end
    end

    // Deadband and hold band
    logic        [15:0] cmag;
    logic        [31:0] emag;
    logic signed [15:0] duty_v;
    always_comb
    begin
        cmag = clamp_reg[15] ? 16'(-clamp_reg) : clamp_reg;
        emag = err_reg[31] ? 32'(-err_reg) : err_reg;
        if ({1'b0, emag} < {2'b0, cfg.hold_band})
        begin
            duty_v = last_duty_reg;
        end
        else if (cmag < {1'b0, cfg.duty_deadband})
        begin
            duty_v = '0;
        end
        else
        begin
            duty_v = clamp_reg;
        end
    end

    // Compare value: floor(|duty| * 65535 / 25600) via /256 then reciprocal of 100
    logic [15:0] dutymag;
    logic [30:0] cvt_x;
    logic [17:0] cvt_q;
    logic [15:0] cmp_v;
    logic        duty_pos;
    logic        rev_v;
    always_comb
    begin
        dutymag  = duty_reg[15] ? 16'(-duty_reg) : duty_reg;
        cvt_x    = {dutymag[14:0], 16'b0} - {15'b0, dutymag};
        cvt_q    = prod[RECIP_SHIFT +: 18];
        cmp_v    = (cvt_q > {2'b0, CMP_MAX}) ? CMP_MAX : cvt_q[15:0];
        duty_pos = (duty_reg > 16'sd0);
        rev_v    = ((last_duty_reg > 16'sd0) && (duty_reg < 16'sd0))
                || ((last_duty_reg < 16'sd0) && (duty_reg > 16'sd0));
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     state_next = accept ? ST_SPD_MUL : ST_IDLE;
            ST_SPD_MUL:  state_next = ST_SPEED;
            ST_SPEED:    state_next = ST_ERROR;
            ST_ERROR:    state_next = ST_INTEG;
            ST_INTEG:    state_next = ST_TERM_LO;
            ST_TERM_LO:  state_next = ST_TERM_HI;
            ST_TERM_HI:  state_next = ST_TERM_ACC;
            ST_TERM_ACC: state_next = (term_sel_reg == TERM_D) ? ST_CLAMP : ST_TERM_LO;
            ST_CLAMP:    state_next = ST_DUTY;
            ST_DUTY:     state_next = ST_CVT_MUL;
            ST_CVT_MUL:  state_next = ST_DONE;
            ST_DONE:     state_next = out_free ? ST_IDLE : ST_DONE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        mul_req     = '0;
        in_ch.ready = 1'b0;
        load        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
            end
            ST_SPD_MUL:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = {8'b0, dmag_reg};
                mul_req.b  = cfg.speed_scale;
            end
            ST_TERM_LO:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = term_mag[23:0];
                mul_req.b  = term_gain;
            end
            ST_TERM_HI:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = term_mag[47:24];
                mul_req.b  = term_gain;
            end
            ST_CVT_MUL:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = {1'b0, cvt_x[30:8]};
                mul_req.b  = RECIP_100;
            end
            ST_DONE:
            begin
                load = out_free;
            end
            default:
            begin
                mul_req = '0;
            end
        endcase
    end

    // Output valid
    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            integ_reg     <= '0;
            last_err_reg  <= '0;
            last_duty_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                integ_reg     <= integ_new_reg;
                last_err_reg  <= err_reg;
                last_duty_reg <= duty_reg;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    dneg_reg <= diff[16];
                    dmag_reg <= diff[16] ? 16'(-diff) : diff[15:0];
                    setp_reg <= in_ch.setpoint_speed;
                end
            end
            ST_SPEED:
            begin
                speed_reg <= sat33(spd_q);
            end
            ST_ERROR:
            begin
                err_reg <= sat33({setp_reg[31], setp_reg} - {speed_reg[31], speed_reg});
            end
            ST_INTEG:
            begin
                deriv_reg     <= {err_reg[31], err_reg} - {last_err_reg[31], last_err_reg};
                integ_new_reg <= isat;
                sum_reg       <= '0;
                term_sel_reg  <= TERM_P;
            end
            ST_TERM_HI:
            begin
                part_reg <= prod[47:16];
            end
            ST_TERM_ACC:
            begin
                sum_reg      <= sum_reg + term_s;
                term_sel_reg <= term_sel_reg + 2'd1;
            end
            ST_CLAMP:
            begin
                clamp_reg <= clamp_v;
            end
            ST_DUTY:
            begin
                duty_reg <= duty_v;
            end
            ST_DONE:
            begin
                if (load)
                begin
                    out_speed_reg <= speed_reg;
                    out_duty_reg  <= duty_reg;
                    out_fwd_reg   <= duty_pos ? cmp_v : '0;
                    out_rev_reg   <= duty_pos ? '0 : cmp_v;
                    out_revf_reg  <= rev_v;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.measured_speed  = out_speed_reg;
    assign out_ch.duty_value      = out_duty_reg;
    assign out_ch.forward_compare = out_fwd_reg;
    assign out_ch.reverse_compare = out_rev_reg;
    assign out_ch.reversal        = out_revf_reg;

endmodule
